>>> rtl/ocp_pkg.sv
// Shared constants, command and register codes, and the sine table for the orbit camera block.
package ocp_pkg;

    localparam int TRIG_FRAC_BITS = 14;
    localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
    localparam int MUL_A_W        = TRIG_W + 16;
    localparam int PROD_W         = MUL_A_W + TRIG_W;
    localparam int ANGLE_W        = 9;
    localparam int DIST_W         = 16;
    localparam int STEP_W         = 10;
    localparam int AMOUNT_W       = 17;
    localparam int LOOK_W         = 17;
    localparam int UP_W           = 16;
    localparam int POS_W          = 18;
    localparam int KIND_W         = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 17;

    localparam logic [KIND_W-1:0] KIND_TILT     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ROTATE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MOVE     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SET_DIST = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SET_ELEV = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SET_AZIM = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOK_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOK_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOK_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_BASE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_BASE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_BASE_Z = 3'd5;

    localparam logic [DIST_W-1:0] DIST_MIN = 16'd2048;
    localparam logic [DIST_W-1:0] DIST_MAX = 16'd25600;

    localparam int FULL_TURN          = 360;
    localparam int QUARTER_TURN       = 90;
    localparam int HALF_TURN          = 180;
    localparam int THREE_QUARTER_TURN = 270;

    localparam logic signed [UP_W-1:0] UP_RESET_Y = 16'sd16384;

    localparam int ROM_SH_DN = (TRIG_FRAC_BITS < 14) ? 14 - TRIG_FRAC_BITS : 0;
    localparam int ROM_SH_UP = (TRIG_FRAC_BITS > 14) ? TRIG_FRAC_BITS - 14 : 0;
    localparam int ROM_RND   = (2 ** ROM_SH_DN) / 2;

    localparam logic [14:0] SINE_ROM [0:90] = '{
            0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
         2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
         5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
         8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    function automatic logic signed [TRIG_W-1:0] rom_scaled(input logic [6:0] k);
        int v;
        v = int'(SINE_ROM[k]);
        v = ((v + ROM_RND) >>> ROM_SH_DN) <<< ROM_SH_UP;
        return TRIG_W'(v);
    endfunction

    // Sine or cosine of a whole-degree angle in 0..359, folded onto the first quadrant.
    function automatic logic signed [TRIG_W-1:0] trig_deg(input logic [ANGLE_W-1:0] angle,
                                                          input logic cosine);
        logic [ANGLE_W:0] a;
        logic [6:0]       k;
        logic             neg;
        a = {1'b0, angle} + (cosine ? 10'(QUARTER_TURN) : 10'd0);
        if (a >= 10'(FULL_TURN))
        begin
            a = a - 10'(FULL_TURN);
        end
        if (a <= 10'(QUARTER_TURN))
        begin
            k   = a[6:0];
            neg = 1'b0;
        end
        else if (a <= 10'(HALF_TURN))
        begin
            k   = 7'(10'(HALF_TURN) - a);
            neg = 1'b0;
        end
        else if (a <= 10'(THREE_QUARTER_TURN))
        begin
            k   = 7'(a - 10'(HALF_TURN));
            neg = 1'b1;
        end
        else
        begin
            k   = 7'(10'(FULL_TURN) - a);
            neg = 1'b1;
        end
        return neg ? -rom_scaled(k) : rom_scaled(k);
    endfunction

endpackage

>>> rtl/orbit_camera_position_top.sv
// Orbit camera command processor: angle, distance and flip update followed by a position solve.
// Each accepted command leaves the block busy: S_UPDATE updates the angles, distance and
// flip flag, S_MUL_T through S_MUL_Z drive the single shared multiplier through
// d*cos(el), d*sin(el), t*cos(az) and t*sin(az), and S_FIN rounds the last product and
// loads the result register. The next command is taken in S_IDLE once the result is
// loaded into the result register, so a command is not taken while another is still in
// progress, and S_FIN holds while the result side is stalled; the result
// register waits for a stalled beat to leave before taking the next one.
module orbit_camera_position_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    output logic                               cmd_stall,
    input  logic [ocp_pkg::KIND_W-1:0]         kind,
    input  logic signed [ocp_pkg::STEP_W-1:0]  step_degrees,
    input  logic signed [ocp_pkg::AMOUNT_W-1:0] amount,
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic [ocp_pkg::ANGLE_W-1:0]        elevation,
    output logic [ocp_pkg::ANGLE_W-1:0]        azimuth,
    output logic [ocp_pkg::DIST_W-1:0]         range_now,
    output logic                               flipped,
    output logic signed [ocp_pkg::POS_W-1:0]   pos_x,
    output logic signed [ocp_pkg::POS_W-1:0]   pos_y,
    output logic signed [ocp_pkg::POS_W-1:0]   pos_z,
    output logic signed [ocp_pkg::UP_W-1:0]    up_x,
    output logic signed [ocp_pkg::UP_W-1:0]    up_y,
    output logic signed [ocp_pkg::UP_W-1:0]    up_z,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ocp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ocp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ocp_pkg::*;

    localparam int SUM_W  = 12;
    localparam int MOVE_W = DIST_W + 3;
    localparam int DIFF_W = PROD_W + 3;

    localparam logic [PROD_W:0] RND_F  = (PROD_W + 1)'(1) << (TRIG_FRAC_BITS - 1);
    localparam logic [PROD_W:0] RND_2F = (PROD_W + 1)'(1) << (2 * TRIG_FRAC_BITS - 1);
    localparam logic signed [DIFF_W-1:0] POS_LO = DIFF_W'(-131072);
    localparam logic signed [DIFF_W-1:0] POS_HI = DIFF_W'(131071);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_UPDATE,
        S_MUL_T,
        S_MUL_Y,
        S_MUL_X,
        S_MUL_Z,
        S_FIN
    } state_t;

    state_t                        state_reg, state_next;
    logic [KIND_W-1:0]             kind_reg, kind_next;
    logic signed [STEP_W-1:0]      step_reg, step_next;
    logic signed [AMOUNT_W-1:0]    amount_reg, amount_next;
    logic [ANGLE_W-1:0]            elev_reg, elev_next;
    logic [ANGLE_W-1:0]            azim_reg, azim_next;
    logic [DIST_W-1:0]             dist_reg, dist_next;
    logic                          flip_reg, flip_next;
    logic signed [LOOK_W-1:0]      look_x_reg, look_x_next;
    logic signed [LOOK_W-1:0]      look_y_reg, look_y_next;
    logic signed [LOOK_W-1:0]      look_z_reg, look_z_next;
    logic signed [UP_W-1:0]        up_base_x_reg, up_base_x_next;
    logic signed [UP_W-1:0]        up_base_y_reg, up_base_y_next;
    logic signed [UP_W-1:0]        up_base_z_reg, up_base_z_next;
    logic signed [PROD_W-1:0]      prod_reg, prod_next;
    logic signed [MUL_A_W-1:0]     t_reg, t_next;
    logic signed [POS_W-1:0]       pos_x_tmp_reg, pos_x_tmp_next;
    logic signed [POS_W-1:0]       pos_y_tmp_reg, pos_y_tmp_next;
    logic                          res_valid_reg, res_valid_next;
    logic [ANGLE_W-1:0]            elevation_reg, elevation_next;
    logic [ANGLE_W-1:0]            azimuth_reg, azimuth_next;
    logic [DIST_W-1:0]             range_now_reg, range_now_next;
    logic                          flipped_reg, flipped_next;
    logic signed [POS_W-1:0]       pos_x_reg, pos_x_next;
    logic signed [POS_W-1:0]       pos_y_reg, pos_y_next;
    logic signed [POS_W-1:0]       pos_z_reg, pos_z_next;
    logic signed [UP_W-1:0]        up_x_reg, up_x_next;
    logic signed [UP_W-1:0]        up_y_reg, up_y_next;
    logic signed [UP_W-1:0]        up_z_reg, up_z_next;

    logic signed [STEP_W:0]        step_ext;
    logic signed [STEP_W:0]        rot_step;
    logic [ANGLE_W-1:0]            tilt_base;
    logic [ANGLE_W-1:0]            rot_base;
    logic [ANGLE_W-1:0]            new_elev;
    logic [ANGLE_W-1:0]            new_azim;
    logic                          new_flip;
    logic signed [MOVE_W-1:0]      move_sum;
    logic [DIST_W-1:0]             move_dist;
    logic [DIST_W-1:0]             set_dist;

    logic [ANGLE_W-1:0]            trig_angle;
    logic                          trig_cos;
    logic signed [TRIG_W-1:0]      trig_val;
    logic signed [MUL_A_W-1:0]     mul_a;
    logic signed [PROD_W-1:0]      mul_p;

    logic                          prod_neg;
    logic [PROD_W-1:0]             prod_mag;
    logic [PROD_W:0]               sum_f;
    logic [PROD_W:0]               sum_2f;
    logic                          use_2f;
    logic [PROD_W:0]               rnd_mag;
    logic signed [PROD_W+1:0]      rnd_val;
    logic signed [LOOK_W-1:0]      look_sel;
    logic signed [DIFF_W-1:0]      diff;
    logic signed [POS_W-1:0]       pos_clamped;
    logic                          res_free;

    function automatic logic [ANGLE_W-1:0] wrap_angle(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] v;
        v = s;
        if (v < 0)
        begin
            v = v + SUM_W'(FULL_TURN);
        end
        if (v < 0)
        begin
            v = v + SUM_W'(FULL_TURN);
        end
        if (v >= SUM_W'(FULL_TURN))
        begin
            v = v - SUM_W'(FULL_TURN);
        end
        if (v >= SUM_W'(FULL_TURN))
        begin
            v = v - SUM_W'(FULL_TURN);
        end
        return v[ANGLE_W-1:0];
    endfunction

    function automatic logic signed [UP_W-1:0] up_value(input logic signed [UP_W-1:0] base,
                                                        input logic flip);
        if (!flip)
        begin
            return base;
        end
        if (base == {1'b1, {(UP_W-1){1'b0}}})
        begin
            return {1'b0, {(UP_W-1){1'b1}}};
        end
        return -base;
    endfunction

    // Command update: angle wrap, flip hysteresis and distance limits for moves.
    always_comb
    begin
        step_ext  = {step_reg[STEP_W-1], step_reg};
        rot_step  = flip_reg ? -step_ext : step_ext;
        tilt_base = (kind_reg == KIND_SET_ELEV) ? '0 : elev_reg;
        rot_base  = (kind_reg == KIND_SET_AZIM) ? '0 : azim_reg;
        new_elev  = wrap_angle(SUM_W'(signed'({1'b0, tilt_base})) + SUM_W'(step_ext));
        new_azim  = wrap_angle(SUM_W'(signed'({1'b0, rot_base})) + SUM_W'(rot_step));
        new_flip  = flip_reg;
        if (!flip_reg && new_elev >= ANGLE_W'(QUARTER_TURN)
            && new_elev <= ANGLE_W'(THREE_QUARTER_TURN))
        begin
            new_flip = 1'b1;
        end
        else if (flip_reg && (new_elev <= ANGLE_W'(QUARTER_TURN)
                 || new_elev >= ANGLE_W'(THREE_QUARTER_TURN)))
        begin
            new_flip = 1'b0;
        end
        move_sum = signed'(MOVE_W'(dist_reg)) + MOVE_W'(amount_reg);
        if (move_sum < signed'(MOVE_W'(DIST_MIN)))
        begin
            move_dist = DIST_MIN;
        end
        else if (move_sum > signed'(MOVE_W'(DIST_MAX)))
        begin
            move_dist = DIST_MAX;
        end
        else
        begin
            move_dist = move_sum[DIST_W-1:0];
        end
        set_dist = amount_reg[AMOUNT_W-1] ? '0 : amount_reg[DIST_W-1:0];
    end

    // Shared sine lookup and multiplier.
    always_comb
    begin
        trig_angle = (state_reg == S_MUL_T || state_reg == S_MUL_Y) ? elev_reg : azim_reg;
        trig_cos   = (state_reg == S_MUL_T || state_reg == S_MUL_X);
        trig_val   = trig_deg(trig_angle, trig_cos);
        mul_a      = (state_reg == S_MUL_X || state_reg == S_MUL_Z) ? t_reg
                                                                  : signed'(MUL_A_W'(dist_reg));
        mul_p      = mul_a * trig_val;
    end

    // Round half away from zero, subtract the look-at point and clamp.
    always_comb
    begin
        prod_neg = prod_reg[PROD_W-1];
        prod_mag = prod_neg ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        sum_f    = {1'b0, prod_mag} + RND_F;
        sum_2f   = {1'b0, prod_mag} + RND_2F;
        use_2f   = (state_reg != S_MUL_X);
        rnd_mag  = use_2f ? (sum_2f >> (2 * TRIG_FRAC_BITS)) : (sum_f >> TRIG_FRAC_BITS);
        rnd_val  = prod_neg ? -signed'({1'b0, rnd_mag}) : signed'({1'b0, rnd_mag});
        unique case (state_reg)
            S_MUL_X: look_sel = look_y_reg;
            S_MUL_Z: look_sel = look_x_reg;
            default: look_sel = look_z_reg;
        endcase
        diff = DIFF_W'(rnd_val) - DIFF_W'(look_sel);
        if (diff < POS_LO)
        begin
            pos_clamped = POS_LO[POS_W-1:0];
        end
        else if (diff > POS_HI)
        begin
            pos_clamped = POS_HI[POS_W-1:0];
        end
        else
        begin
            pos_clamped = diff[POS_W-1:0];
        end
    end

    assign res_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        step_next      = step_reg;
        amount_next    = amount_reg;
        elev_next      = elev_reg;
        azim_next      = azim_reg;
        dist_next      = dist_reg;
        flip_next      = flip_reg;
        look_x_next    = look_x_reg;
        look_y_next    = look_y_reg;
        look_z_next    = look_z_reg;
        up_base_x_next = up_base_x_reg;
        up_base_y_next = up_base_y_reg;
        up_base_z_next = up_base_z_reg;
        prod_next      = prod_reg;
        t_next         = t_reg;
        pos_x_tmp_next = pos_x_tmp_reg;
        pos_y_tmp_next = pos_y_tmp_reg;
        res_valid_next = res_valid_reg && res_stall;
        elevation_next = elevation_reg;
        azimuth_next   = azimuth_reg;
        range_now_next = range_now_reg;
        flipped_next   = flipped_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        pos_z_next     = pos_z_reg;
        up_x_next      = up_x_reg;
        up_y_next      = up_y_reg;
        up_z_next      = up_z_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LOOK_X:    look_x_next    = signed'(cfg_data);
                CFG_LOOK_Y:    look_y_next    = signed'(cfg_data);
                CFG_LOOK_Z:    look_z_next    = signed'(cfg_data);
                CFG_UP_BASE_X: up_base_x_next = signed'(cfg_data[UP_W-1:0]);
                CFG_UP_BASE_Y: up_base_y_next = signed'(cfg_data[UP_W-1:0]);
                CFG_UP_BASE_Z: up_base_z_next = signed'(cfg_data[UP_W-1:0]);
                default:       ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    kind_next   = kind;
                    step_next   = step_degrees;
                    amount_next = amount;
                    state_next  = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                unique case (kind_reg) inside
                    KIND_TILT, KIND_SET_ELEV:
                    begin
                        elev_next = new_elev;
                        flip_next = new_flip;
                    end
                    KIND_ROTATE, KIND_SET_AZIM: azim_next = new_azim;
                    KIND_MOVE:                  dist_next = move_dist;
                    KIND_SET_DIST:              dist_next = set_dist;
                    default:                    ;
                endcase
                state_next = S_MUL_T;
            end
            S_MUL_T:
            begin
                prod_next  = mul_p;
                state_next = S_MUL_Y;
            end
            S_MUL_Y:
            begin
                t_next     = prod_reg[MUL_A_W-1:0];
                prod_next  = mul_p;
                state_next = S_MUL_X;
            end
            S_MUL_X:
            begin
                pos_y_tmp_next = pos_clamped;
                prod_next      = mul_p;
                state_next     = S_MUL_Z;
            end
            S_MUL_Z:
            begin
                pos_x_tmp_next = pos_clamped;
                prod_next      = mul_p;
                state_next     = S_FIN;
            end
            S_FIN:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    elevation_next = elev_reg;
                    azimuth_next   = azim_reg;
                    range_now_next = dist_reg;
                    flipped_next   = flip_reg;
                    pos_x_next     = pos_x_tmp_reg;
                    pos_y_next     = pos_y_tmp_reg;
                    pos_z_next     = pos_clamped;
                    up_x_next      = up_value(up_base_x_reg, flip_reg);
                    up_y_next      = up_value(up_base_y_reg, flip_reg);
                    up_z_next      = up_value(up_base_z_reg, flip_reg);
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= '0;
            step_reg      <= '0;
            amount_reg    <= '0;
            elev_reg      <= '0;
            azim_reg      <= '0;
            dist_reg      <= '0;
            flip_reg      <= 1'b0;
            look_x_reg    <= '0;
            look_y_reg    <= '0;
            look_z_reg    <= '0;
            up_base_x_reg <= '0;
            up_base_y_reg <= UP_RESET_Y;
            up_base_z_reg <= '0;
            prod_reg      <= '0;
            t_reg         <= '0;
            pos_x_tmp_reg <= '0;
            pos_y_tmp_reg <= '0;
            res_valid_reg <= 1'b0;
            elevation_reg <= '0;
            azimuth_reg   <= '0;
            range_now_reg <= '0;
            flipped_reg   <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            pos_z_reg     <= '0;
            up_x_reg      <= '0;
            up_y_reg      <= '0;
            up_z_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            step_reg      <= step_next;
            amount_reg    <= amount_next;
            elev_reg      <= elev_next;
            azim_reg      <= azim_next;
            dist_reg      <= dist_next;
            flip_reg      <= flip_next;
            look_x_reg    <= look_x_next;
            look_y_reg    <= look_y_next;
            look_z_reg    <= look_z_next;
            up_base_x_reg <= up_base_x_next;
            up_base_y_reg <= up_base_y_next;
            up_base_z_reg <= up_base_z_next;
            prod_reg      <= prod_next;
            t_reg         <= t_next;
            pos_x_tmp_reg <= pos_x_tmp_next;
            pos_y_tmp_reg <= pos_y_tmp_next;
            res_valid_reg <= res_valid_next;
            elevation_reg <= elevation_next;
            azimuth_reg   <= azimuth_next;
            range_now_reg <= range_now_next;
            flipped_reg   <= flipped_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            pos_z_reg     <= pos_z_next;
            up_x_reg      <= up_x_next;
            up_y_reg      <= up_y_next;
            up_z_reg      <= up_z_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign elevation = elevation_reg;
    assign azimuth   = azimuth_reg;
    assign range_now = range_now_reg;
    assign flipped   = flipped_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;
    assign up_x      = up_x_reg;
    assign up_y      = up_y_reg;
    assign up_z      = up_z_reg;

    // A new result beat can only come out of the final solve step.
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(state_reg == S_FIN))
        else $error("result raised outside the final solve step");

    // An accepted command keeps the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("command port free straight after an accepted beat");

    // A move always leaves the distance inside its limits.
    a_move_limits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MUL_T && kind_reg == KIND_MOVE
        |-> dist_reg >= DIST_MIN && dist_reg <= DIST_MAX)
        else $error("distance outside limits after a move");

    // Reported angles stay within one turn.
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> elevation < ANGLE_W'(FULL_TURN) && azimuth < ANGLE_W'(FULL_TURN))
        else $error("reported angle outside one turn");

endmodule
